[sv/pbct_pkg.sv]
// ----------------------------------------------------------------------------
// pbct_pkg - shared definitions for the point box cull / transform block
// Holds the field widths, the request codes and the transaction structs that
// travel along the box cell chain and out of the transform unit.
// ----------------------------------------------------------------------------
package pbct_pkg;

   // Fixed field widths
   localparam int WORD_BITS  = 32;
   localparam int SLOT_BITS  = 4;
   localparam int COLOR_BITS = 8;
   localparam int FRAC_BITS  = 16;

   // Sizing of the box chain and of the saturation range
   localparam int BOX_SLOTS    = 16;
   localparam int COORD_BITS   = 32;
   localparam int CELL_ID_BITS = (BOX_SLOTS > (1 << SLOT_BITS)) ? $clog2(BOX_SLOTS) : SLOT_BITS;

   // Affine coefficient layout: row-major, three matrix terms then offset
   localparam int NUM_COEF        = 12;
   localparam int NUM_ROWS        = 3;
   localparam int COEF_ROW_STRIDE = 4;
   localparam int OFFSET_COL      = 3;
   localparam int COEF_XX         = 0;
   localparam int COEF_YY         = 5;
   localparam int COEF_ZZ         = 10;
   localparam logic signed [WORD_BITS-1:0] ONE_Q16 = WORD_BITS'(1 << FRAC_BITS);

   // Arithmetic widths of the transform
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int ACC_BITS  = 52;

   typedef enum logic [1:0] {
      REQ_POINT       = 2'd0,
      REQ_BOX_WRITE   = 2'd1,
      REQ_BOX_DISABLE = 2'd2,
      REQ_COEF_WRITE  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic                          valid;
      req_kind_type                  kind;
      logic signed [WORD_BITS-1:0]   x;
      logic signed [WORD_BITS-1:0]   y;
      logic signed [WORD_BITS-1:0]   z;
      logic signed [WORD_BITS-1:0]   cx;
      logic signed [WORD_BITS-1:0]   cy;
      logic signed [WORD_BITS-1:0]   cz;
      logic [COLOR_BITS-1:0]         r;
      logic [COLOR_BITS-1:0]         g;
      logic [COLOR_BITS-1:0]         b;
      logic [SLOT_BITS-1:0]          slot;
      logic                          last;
      logic                          drop;
   } item_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0]   x;
      logic signed [WORD_BITS-1:0]   y;
      logic signed [WORD_BITS-1:0]   z;
      logic [COLOR_BITS-1:0]         r;
      logic [COLOR_BITS-1:0]         g;
      logic [COLOR_BITS-1:0]         b;
      logic [WORD_BITS-1:0]          index;
      logic                          kept;
      logic                          cloud_end;
      logic                          sat;
   } result_type;

endpackage

[sv/pbct_if.sv]
// ----------------------------------------------------------------------------
// pbct_if - request and response channels
// Valid/ready channels; a transaction moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface pbct_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             req_type;
   logic signed [pbct_pkg::WORD_BITS-1:0]  coord_x;
   logic signed [pbct_pkg::WORD_BITS-1:0]  coord_y;
   logic signed [pbct_pkg::WORD_BITS-1:0]  coord_z;
   logic signed [pbct_pkg::WORD_BITS-1:0]  corner_x;
   logic signed [pbct_pkg::WORD_BITS-1:0]  corner_y;
   logic signed [pbct_pkg::WORD_BITS-1:0]  corner_z;
   logic [pbct_pkg::COLOR_BITS-1:0]        color_r;
   logic [pbct_pkg::COLOR_BITS-1:0]        color_g;
   logic [pbct_pkg::COLOR_BITS-1:0]        color_b;
   logic [pbct_pkg::SLOT_BITS-1:0]         slot;
   logic                                   point_last;

   modport source (output valid, req_type, coord_x, coord_y, coord_z, corner_x, corner_y,
                   corner_z, color_r, color_g, color_b, slot, point_last, input ready);
   modport sink   (input valid, req_type, coord_x, coord_y, coord_z, corner_x, corner_y,
                   corner_z, color_r, color_g, color_b, slot, point_last, output ready);
endinterface

interface pbct_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pbct_pkg::WORD_BITS-1:0]  out_x;
   logic signed [pbct_pkg::WORD_BITS-1:0]  out_y;
   logic signed [pbct_pkg::WORD_BITS-1:0]  out_z;
   logic [pbct_pkg::COLOR_BITS-1:0]        out_r;
   logic [pbct_pkg::COLOR_BITS-1:0]        out_g;
   logic [pbct_pkg::COLOR_BITS-1:0]        out_b;
   logic [pbct_pkg::WORD_BITS-1:0]         kept_index;
   logic                                   point_kept;
   logic                                   cloud_end;
   logic                                   saturated;

   modport source (output valid, out_x, out_y, out_z, out_r, out_g, out_b, kept_index,
                   point_kept, cloud_end, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_r, out_g, out_b, kept_index,
                   point_kept, cloud_end, saturated, output ready);
endinterface

[sv/pbct_box_cell.sv]
// ----------------------------------------------------------------------------
// pbct_box_cell - one deletion box of the culling chain
// Holds one box and its enable, tests each passing point against it and
// takes box writes and box disables addressed to its own slot.
// ----------------------------------------------------------------------------
module pbct_box_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic [pbct_pkg::CELL_ID_BITS-1:0]    cell_id,
   input  pbct_pkg::item_type                   item_in,
   output pbct_pkg::item_type                   item_out
);
   import pbct_pkg::*;

   logic signed [WORD_BITS-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic signed [WORD_BITS-1:0] max_x_ff, max_y_ff, max_z_ff;
   logic                        en_ff;
   item_type                    item_ff;
   item_type                    item_in_next;
   logic                        slot_hit;
   logic                        in_box;
   logic                        box_wr;

   assign slot_hit = (CELL_ID_BITS'(item_in.slot) == cell_id);
   assign box_wr   = item_in.valid && slot_hit && (item_in.kind == REQ_BOX_WRITE);

   assign in_box = en_ff &&
                   (item_in.x >= min_x_ff) && (item_in.x <= max_x_ff) &&
                   (item_in.y >= min_y_ff) && (item_in.y <= max_y_ff) &&
                   (item_in.z >= min_z_ff) && (item_in.z <= max_z_ff);

   always_comb begin
      item_in_next      = item_in;
      item_in_next.drop = item_in.drop || ((item_in.kind == REQ_POINT) && in_box);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff         <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (adv) begin
         item_ff <= item_in_next;
         if (item_in.valid && slot_hit) begin
            case (item_in.kind)
               REQ_BOX_WRITE:   en_ff <= 1'b1;
               REQ_BOX_DISABLE: en_ff <= 1'b0;
               default:         en_ff <= en_ff;
            endcase
         end
      end
   end

   // Box bounds: order each corner pair on the way in
   always_ff @(posedge clock) begin
      if (adv && box_wr) begin
         min_x_ff <= (item_in.x > item_in.cx) ? item_in.cx : item_in.x;
         max_x_ff <= (item_in.x > item_in.cx) ? item_in.x  : item_in.cx;
         min_y_ff <= (item_in.y > item_in.cy) ? item_in.cy : item_in.y;
         max_y_ff <= (item_in.y > item_in.cy) ? item_in.y  : item_in.cy;
         min_z_ff <= (item_in.z > item_in.cz) ? item_in.cz : item_in.z;
         max_z_ff <= (item_in.z > item_in.cz) ? item_in.z  : item_in.cz;
      end
   end

   assign item_out = item_ff;

endmodule

[sv/pbct_xform.sv]
// ----------------------------------------------------------------------------
// pbct_xform - affine transform and result stage
// Holds the coefficients and the kept-point count, multiplies, sums with
// rounding, adds the offset, saturates and registers the result.
// ----------------------------------------------------------------------------
module pbct_xform (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  pbct_pkg::item_type    item_in,
   output logic                  rsp_valid,
   output pbct_pkg::result_type  rsp_data
);
   import pbct_pkg::*;

   typedef struct packed {
      logic [COLOR_BITS-1:0] r;
      logic [COLOR_BITS-1:0] g;
      logic [COLOR_BITS-1:0] b;
      logic [WORD_BITS-1:0]  index;
      logic                  kept;
      logic                  last;
   } tag_type;

   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      {{(ACC_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

   logic signed [WORD_BITS-1:0]  coef_ff [NUM_COEF];
   logic [WORD_BITS-1:0]         kept_count_ff;

   logic                         is_point;
   logic                         emit;
   logic signed [WORD_BITS-1:0]  coord [NUM_ROWS];
   logic signed [PROD_BITS-1:0]  prod [NUM_ROWS][NUM_ROWS];
   tag_type                      tag_next;

   logic                         s1_valid_ff;
   logic signed [PROD_BITS-1:0]  s1_prod_ff [NUM_ROWS][NUM_ROWS];
   logic signed [WORD_BITS-1:0]  s1_off_ff [NUM_ROWS];
   tag_type                      s1_tag_ff;

   logic                         s2_valid_ff;
   logic signed [SUM_BITS-1:0]   s2_sum_ff [NUM_ROWS];
   logic signed [WORD_BITS-1:0]  s2_off_ff [NUM_ROWS];
   tag_type                      s2_tag_ff;

   logic signed [ACC_BITS-1:0]   row_val [NUM_ROWS];
   logic signed [ACC_BITS-1:0]   sat_val [NUM_ROWS];
   logic [NUM_ROWS-1:0]          clip;

   logic                         rsp_valid_ff;
   result_type                   rsp_data_ff;

   assign is_point = item_in.valid && (item_in.kind == REQ_POINT);
   assign emit     = is_point && (!item_in.drop || item_in.last);

   assign coord[0] = item_in.x;
   assign coord[1] = item_in.y;
   assign coord[2] = item_in.z;

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_ROWS; c++) begin
            prod[r][c] = PROD_BITS'(coef_ff[r * COEF_ROW_STRIDE + c]) *
                         PROD_BITS'(coord[c]);
         end
      end
      tag_next.r     = item_in.r;
      tag_next.g     = item_in.g;
      tag_next.b     = item_in.b;
      tag_next.index = kept_count_ff;
      tag_next.kept  = !item_in.drop;
      tag_next.last  = item_in.last;
   end

   // Control: stage valids, kept count and coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         kept_count_ff <= '0;
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[COEF_XX] <= ONE_Q16;
         coef_ff[COEF_YY] <= ONE_Q16;
         coef_ff[COEF_ZZ] <= ONE_Q16;
      end else if (adv) begin
         s1_valid_ff  <= emit;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
         if (is_point) begin
            if (item_in.last) begin
               kept_count_ff <= '0;
            end else if (!item_in.drop) begin
               kept_count_ff <= kept_count_ff + WORD_BITS'(1);
            end
         end
         if (item_in.valid && (item_in.kind == REQ_COEF_WRITE) &&
             (item_in.slot < SLOT_BITS'(NUM_COEF))) begin
            coef_ff[item_in.slot] <= item_in.x;
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         row_val[r] = ACC_BITS'(s2_sum_ff[r] >>> FRAC_BITS) + ACC_BITS'(s2_off_ff[r]);
         if (row_val[r] > SAT_HI) begin
            sat_val[r] = SAT_HI;
            clip[r]    = 1'b1;
         end else if (row_val[r] < SAT_LO) begin
            sat_val[r] = SAT_LO;
            clip[r]    = 1'b1;
         end else begin
            sat_val[r] = row_val[r];
            clip[r]    = 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= prod;
         for (int r = 0; r < NUM_ROWS; r++) begin
            s1_off_ff[r] <= coef_ff[r * COEF_ROW_STRIDE + OFFSET_COL];
         end
         s1_tag_ff <= tag_next;

         for (int r = 0; r < NUM_ROWS; r++) begin
            s2_sum_ff[r] <= SUM_BITS'(s1_prod_ff[r][0]) + SUM_BITS'(s1_prod_ff[r][1]) +
                            SUM_BITS'(s1_prod_ff[r][2]) + ROUND_HALF;
         end
         s2_off_ff <= s1_off_ff;
         s2_tag_ff <= s1_tag_ff;

         rsp_data_ff.x         <= s2_tag_ff.kept ? sat_val[0][WORD_BITS-1:0] : '0;
         rsp_data_ff.y         <= s2_tag_ff.kept ? sat_val[1][WORD_BITS-1:0] : '0;
         rsp_data_ff.z         <= s2_tag_ff.kept ? sat_val[2][WORD_BITS-1:0] : '0;
         rsp_data_ff.r         <= s2_tag_ff.kept ? s2_tag_ff.r : '0;
         rsp_data_ff.g         <= s2_tag_ff.kept ? s2_tag_ff.g : '0;
         rsp_data_ff.b         <= s2_tag_ff.kept ? s2_tag_ff.b : '0;
         rsp_data_ff.index     <= s2_tag_ff.kept ? s2_tag_ff.index : '0;
         rsp_data_ff.kept      <= s2_tag_ff.kept;
         rsp_data_ff.cloud_end <= s2_tag_ff.last;
         rsp_data_ff.sat       <= s2_tag_ff.kept && (|clip);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.kept) |-> rsp_data_ff.cloud_end)
      else $error("empty result without cloud end");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.kept) |->
         (rsp_data_ff.index == '0) && !rsp_data_ff.sat && (rsp_data_ff.x == '0))
      else $error("empty result carries data");

   a_last_clears_count: assert property (@(posedge clock) disable iff (reset)
      (adv && is_point && item_in.last) |=> (kept_count_ff == '0))
      else $error("kept count not restarted after last point");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

[sv/point_box_cull_transform_top.sv]
// ----------------------------------------------------------------------------
// point_box_cull_transform_top - box culling and affine transform of points
// Streams Q16.16 points through a chain of deletion box cells, then applies
// a 3x4 affine transform to each kept point.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one transaction per request: a point (with colour and
//   last marker), a box write, a box disable or a coefficient write. Boxes
//   and coefficients are loaded in-band and take effect for every point
//   accepted after them, in order.
//   rsp_bus returns one transaction per kept point, plus an empty marker
//   (point_kept low, cloud_end high) when a point marked last is culled.
//   Configuration requests and culled non-last points return nothing.
// Throughput: one request per cycle while no result waits unclaimed.
// Pipeline: a register in each box cell of the chain, then multiply,
//   sum/round and offset/saturate stages, the last of which is the
//   output register.
// Stalls: the whole chain advances as one; while a result waits unclaimed
//   the chain holds and req_bus.ready is low. An empty output register
//   lets the chain advance, so bubbles never block a request.
// Reset: all boxes disabled, identity transform, kept count zero, no result
//   pending. Requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module point_box_cull_transform_top (
   input  logic        clock,
   input  logic        reset,
   pbct_req_if.sink    req_bus,
   pbct_rsp_if.source  rsp_bus
);
   import pbct_pkg::*;

   item_type    chain_item [BOX_SLOTS+1];
   logic        adv;
   logic        rsp_valid;
   result_type  rsp_data;

   // Advance everything whenever the output register is free or being drained
   assign adv           = !rsp_valid || rsp_bus.ready;
   assign req_bus.ready = adv;

   // Head of the chain: the incoming transaction, or a bubble
   always_comb begin
      chain_item[0].valid = req_bus.valid;
      chain_item[0].kind  = req_kind_type'(req_bus.req_type);
      chain_item[0].x     = req_bus.coord_x;
      chain_item[0].y     = req_bus.coord_y;
      chain_item[0].z     = req_bus.coord_z;
      chain_item[0].cx    = req_bus.corner_x;
      chain_item[0].cy    = req_bus.corner_y;
      chain_item[0].cz    = req_bus.corner_z;
      chain_item[0].r     = req_bus.color_r;
      chain_item[0].g     = req_bus.color_g;
      chain_item[0].b     = req_bus.color_b;
      chain_item[0].slot  = req_bus.slot;
      chain_item[0].last  = req_bus.point_last;
      chain_item[0].drop  = 1'b0;
   end

   // One cell per box slot; each hands its transaction to the next every cycle that the chain advances
   for (genvar i = 0; i < BOX_SLOTS; i++) begin : g_cell
      pbct_box_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .cell_id  (CELL_ID_BITS'(i)),
         .item_in  (chain_item[i]),
         .item_out (chain_item[i+1])
      );
   end

   // Transform, kept counting and the output register
   pbct_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .item_in   (chain_item[BOX_SLOTS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.out_x      = rsp_data.x;
   assign rsp_bus.out_y      = rsp_data.y;
   assign rsp_bus.out_z      = rsp_data.z;
   assign rsp_bus.out_r      = rsp_data.r;
   assign rsp_bus.out_g      = rsp_data.g;
   assign rsp_bus.out_b      = rsp_data.b;
   assign rsp_bus.kept_index = rsp_data.index;
   assign rsp_bus.point_kept = rsp_data.kept;
   assign rsp_bus.cloud_end  = rsp_data.cloud_end;
   assign rsp_bus.saturated  = rsp_data.sat;

endmodule

[tb/tb_point_box_cull_transform_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_box_cull_transform_top - box cull and affine transform testbench
// Drives points, box writes, box disables and coefficient writes into the
// block and predicts every response with a bit-accurate software copy of
// the culling and fixed-point transform. Responses are compared field by
// field in order, with random idling on the request side and random
// back-pressure on the response side.
// ----------------------------------------------------------------------------
module tb_point_box_cull_transform_top;
   import pbct_pkg::*;

   // Response latency through the box chain and the transform stages
   localparam int PIPE_LATENCY   = BOX_SLOTS + 3;
   // Cycles with no transaction on either channel before the run is abandoned
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 850;

   typedef struct {
      req_kind_type                 kind;
      logic signed [WORD_BITS-1:0]  x;
      logic signed [WORD_BITS-1:0]  y;
      logic signed [WORD_BITS-1:0]  z;
      logic signed [WORD_BITS-1:0]  cx;
      logic signed [WORD_BITS-1:0]  cy;
      logic signed [WORD_BITS-1:0]  cz;
      logic [COLOR_BITS-1:0]        r;
      logic [COLOR_BITS-1:0]        g;
      logic [COLOR_BITS-1:0]        b;
      logic [SLOT_BITS-1:0]         slot;
      logic                         last;
   } cull_request_type;

   logic clock = 1'b0;
   logic reset;

   pbct_req_if req_bus ();
   pbct_rsp_if rsp_bus ();

   point_box_cull_transform_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow state of the block: deletion boxes, coefficients, kept ordinal
   logic signed [WORD_BITS-1:0] box_lo_x [BOX_SLOTS];
   logic signed [WORD_BITS-1:0] box_lo_y [BOX_SLOTS];
   logic signed [WORD_BITS-1:0] box_lo_z [BOX_SLOTS];
   logic signed [WORD_BITS-1:0] box_hi_x [BOX_SLOTS];
   logic signed [WORD_BITS-1:0] box_hi_y [BOX_SLOTS];
   logic signed [WORD_BITS-1:0] box_hi_z [BOX_SLOTS];
   logic                        box_on   [BOX_SLOTS];
   logic signed [WORD_BITS-1:0] affine   [NUM_COEF];
   logic [WORD_BITS-1:0]        kept_tally;

   result_type pending_results[$];
   int         fail_count     = 0;
   int         requests_taken = 0;
   logic       send_idle_on   = 1'b0;
   logic       recv_idle_on   = 1'b0;

   // Gap length: mostly short, now and then long
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Append one expected response behind those already waiting
   function automatic void queue_result(input result_type res);
      pending_results.insert(pending_results.size(), res);
   endfunction

   // One row of the transform: exact Q32.32 sum, round half up to Q16.16,
   // add the offset, saturate. Bit 32 of the return value flags a clip.
   function automatic logic [WORD_BITS:0] transform_row(int row,
         logic signed [WORD_BITS-1:0] px, logic signed [WORD_BITS-1:0] py,
         logic signed [WORD_BITS-1:0] pz);
      logic signed [71:0] acc, c0, c1, c2, ofs, vx, vy, vz;
      c0  = affine[row * COEF_ROW_STRIDE + 0];
      c1  = affine[row * COEF_ROW_STRIDE + 1];
      c2  = affine[row * COEF_ROW_STRIDE + 2];
      ofs = affine[row * COEF_ROW_STRIDE + OFFSET_COL];
      vx  = px;
      vy  = py;
      vz  = pz;
      acc = c0 * vx + c1 * vy + c2 * vz;
      acc = (acc + 72'sd32768) >>> FRAC_BITS;
      acc = acc + ofs;
      if (acc > 72'sd2147483647)  return {1'b1, 32'h7FFF_FFFF};
      if (acc < -72'sd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, acc[WORD_BITS-1:0]};
   endfunction

   // Advance the shadow state by one accepted transaction and queue the
   // response it should cause, if any
   task automatic cull_and_transform(input cull_request_type rq);
      result_type       res;
      logic             culled;
      logic [WORD_BITS:0] row_x, row_y, row_z;
      case (rq.kind)
         REQ_BOX_WRITE: begin
            if (rq.slot < BOX_SLOTS) begin
               box_lo_x[rq.slot] = (rq.x > rq.cx) ? rq.cx : rq.x;
               box_hi_x[rq.slot] = (rq.x > rq.cx) ? rq.x : rq.cx;
               box_lo_y[rq.slot] = (rq.y > rq.cy) ? rq.cy : rq.y;
               box_hi_y[rq.slot] = (rq.y > rq.cy) ? rq.y : rq.cy;
               box_lo_z[rq.slot] = (rq.z > rq.cz) ? rq.cz : rq.z;
               box_hi_z[rq.slot] = (rq.z > rq.cz) ? rq.z : rq.cz;
               box_on[rq.slot]   = 1'b1;
            end
         end
         REQ_BOX_DISABLE: begin
            if (rq.slot < BOX_SLOTS) box_on[rq.slot] = 1'b0;
         end
         REQ_COEF_WRITE: begin
            if (rq.slot < NUM_COEF) affine[rq.slot] = rq.x;
         end
         default: begin
            culled = 1'b0;
            for (int s = 0; s < BOX_SLOTS; s++)
               if (box_on[s] && rq.x >= box_lo_x[s] && rq.x <= box_hi_x[s] &&
                   rq.y >= box_lo_y[s] && rq.y <= box_hi_y[s] &&
                   rq.z >= box_lo_z[s] && rq.z <= box_hi_z[s])
                  culled = 1'b1;
            res = '0;
            if (culled) begin
               // a culled last point still closes the cloud with an empty marker
               if (rq.last) begin
                  res.cloud_end = 1'b1;
                  kept_tally    = '0;
                  queue_result(res);
               end
            end else begin
               row_x         = transform_row(0, rq.x, rq.y, rq.z);
               row_y         = transform_row(1, rq.x, rq.y, rq.z);
               row_z         = transform_row(2, rq.x, rq.y, rq.z);
               res.x         = row_x[WORD_BITS-1:0];
               res.y         = row_y[WORD_BITS-1:0];
               res.z         = row_z[WORD_BITS-1:0];
               res.r         = rq.r;
               res.g         = rq.g;
               res.b         = rq.b;
               res.index     = kept_tally;
               res.kept      = 1'b1;
               res.cloud_end = rq.last;
               res.sat       = row_x[WORD_BITS] | row_y[WORD_BITS] | row_z[WORD_BITS];
               kept_tally    = rq.last ? '0 : kept_tally + 1;
               queue_result(res);
            end
         end
      endcase
   endtask

   // Present one transaction, hold it until taken, then maybe idle.
   // valid is left high unless a gap follows, so back-to-back items never
   // lower and raise it within one step.
   task automatic send_request(input cull_request_type rq);
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= rq.kind;
      req_bus.coord_x    <= rq.x;
      req_bus.coord_y    <= rq.y;
      req_bus.coord_z    <= rq.z;
      req_bus.corner_x   <= rq.cx;
      req_bus.corner_y   <= rq.cy;
      req_bus.corner_z   <= rq.cz;
      req_bus.color_r    <= rq.r;
      req_bus.color_g    <= rq.g;
      req_bus.color_b    <= rq.b;
      req_bus.slot       <= rq.slot;
      req_bus.point_last <= rq.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      cull_and_transform(rq);
      if (rq.kind != REQ_COEF_WRITE || rq.slot < NUM_COEF) requests_taken++;
      if (send_idle_on && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
   endtask

   // Stop sending until every queued response has come back; always wait on
   // the clock before checking, so valid is never lowered and raised in one step
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Random fill so that unused fields still toggle every bit
   function automatic cull_request_type junk_request();
      cull_request_type rq;
      rq.kind = REQ_POINT;
      rq.x    = $urandom;
      rq.y    = $urandom;
      rq.z    = $urandom;
      rq.cx   = $urandom;
      rq.cy   = $urandom;
      rq.cz   = $urandom;
      rq.r    = COLOR_BITS'($urandom);
      rq.g    = COLOR_BITS'($urandom);
      rq.b    = COLOR_BITS'($urandom);
      rq.slot = SLOT_BITS'($urandom);
      rq.last = 1'($urandom);
      return rq;
   endfunction

   function automatic cull_request_type point_req(logic signed [WORD_BITS-1:0] px,
         logic signed [WORD_BITS-1:0] py, logic signed [WORD_BITS-1:0] pz, logic last);
      cull_request_type rq;
      rq      = junk_request();
      rq.x    = px;
      rq.y    = py;
      rq.z    = pz;
      rq.last = last;
      return rq;
   endfunction

   function automatic cull_request_type box_req(logic [SLOT_BITS-1:0] slot,
         logic signed [WORD_BITS-1:0] ax, logic signed [WORD_BITS-1:0] ay,
         logic signed [WORD_BITS-1:0] az, logic signed [WORD_BITS-1:0] bx,
         logic signed [WORD_BITS-1:0] by, logic signed [WORD_BITS-1:0] bz);
      cull_request_type rq;
      rq      = junk_request();
      rq.kind = REQ_BOX_WRITE;
      rq.slot = slot;
      rq.x    = ax;
      rq.y    = ay;
      rq.z    = az;
      rq.cx   = bx;
      rq.cy   = by;
      rq.cz   = bz;
      return rq;
   endfunction

   function automatic cull_request_type disable_req(logic [SLOT_BITS-1:0] slot);
      cull_request_type rq;
      rq      = junk_request();
      rq.kind = REQ_BOX_DISABLE;
      rq.slot = slot;
      return rq;
   endfunction

   function automatic cull_request_type coef_req(logic [SLOT_BITS-1:0] idx,
         logic signed [WORD_BITS-1:0] value);
      cull_request_type rq;
      rq      = junk_request();
      rq.kind = REQ_COEF_WRITE;
      rq.slot = idx;
      rq.x    = value;
      return rq;
   endfunction

   // Coordinate around +-256.0, where the random boxes live
   function automatic logic signed [WORD_BITS-1:0] near_coord();
      return $signed($urandom_range(0, 33554432)) - 16777216;
   endfunction

   // Pick a value on a bound, just below the lower bound, or inside
   function automatic logic signed [WORD_BITS-1:0] pick_between(
         logic signed [WORD_BITS-1:0] lo, logic signed [WORD_BITS-1:0] hi);
      longint          span;
      longint unsigned roll;
      span = longint'(hi) - longint'(lo);
      roll = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return lo;
         1: return hi;
         2: return (lo == 32'sh8000_0000) ? lo : lo - 1;
         default: return WORD_BITS'(lo + (roll % (span + 1)));
      endcase
   endfunction

   function automatic logic signed [WORD_BITS-1:0] random_coef(logic [SLOT_BITS-1:0] idx);
      int roll;
      roll = $urandom_range(0, 99);
      // canonical identity value keeps the transform from drifting into clip
      if (roll < 15)
         return (idx == COEF_XX || idx == COEF_YY || idx == COEF_ZZ) ? ONE_Q16 : '0;
      if (roll < 65) return $signed($urandom_range(0, 131072)) - 65536;
      if (roll < 88) return $signed($urandom_range(0, 2097152)) - 1048576;
      return $urandom;
   endfunction

   // One random box write, disable or coefficient write
   task automatic random_setup_step();
      logic [SLOT_BITS-1:0] slot;
      int                   roll;
      slot = SLOT_BITS'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         if ($urandom_range(0, 3) != 0)
            send_request(box_req(slot, near_coord(), near_coord(), near_coord(),
                                 near_coord(), near_coord(), near_coord()));
         else
            send_request(box_req(slot, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom));
      end else if (roll < 70) begin
         send_request(disable_req(slot));
      end else begin
         send_request(coef_req(slot, random_coef(slot)));
      end
   endtask

   // Random point: near the origin, anywhere, or on and around a live box
   task automatic random_point(input logic last);
      int                   roll;
      int                   live;
      logic [SLOT_BITS-1:0] slot;
      roll = $urandom_range(0, 99);
      live = -1;
      slot = SLOT_BITS'($urandom);
      for (int s = 0; s < BOX_SLOTS; s++)
         if (box_on[(slot + s) % BOX_SLOTS] && live < 0) live = (slot + s) % BOX_SLOTS;
      if (roll < 35 && live >= 0)
         send_request(point_req(pick_between(box_lo_x[live], box_hi_x[live]),
                                pick_between(box_lo_y[live], box_hi_y[live]),
                                pick_between(box_lo_z[live], box_hi_z[live]), last));
      else if (roll < 80)
         send_request(point_req(near_coord(), near_coord(), near_coord(), last));
      else
         send_request(point_req($urandom, $urandom, $urandom, last));
   endtask

   // Identity transform must pass coordinates and colours straight through
   task automatic test_identity_passthrough();
      cull_request_type rq;
      rq   = point_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
      rq.r = 8'hFF;
      rq.g = 8'hFF;
      rq.b = 8'hFF;
      send_request(rq);
      rq   = point_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
      rq.r = 8'h00;
      rq.g = 8'h00;
      rq.b = 8'h00;
      send_request(rq);
      send_request(point_req('0, '0, '0, 1'b0));
      send_request(point_req(32'sh0001_0000, -32'sh0001_0000, 32'sh1, 1'b1));
   endtask

   // Swapped corners, inclusive bounds, empty end marker, disable
   task automatic test_box_culling();
      send_request(box_req(4'(BOX_SLOTS - 1), 32'sd655360, -32'sd327680, 32'sd131072,
                           -32'sd655360, 32'sd327680, -32'sd131072));
      send_request(point_req(-32'sd655360, -32'sd327680, -32'sd131072, 1'b0));
      send_request(point_req(32'sd655360, 32'sd327680, 32'sd131072, 1'b1));
      send_request(point_req(32'sd655361, '0, '0, 1'b0));
      send_request(disable_req(4'(BOX_SLOTS - 1)));
      send_request(point_req('0, '0, '0, 1'b1));
   endtask

   // Ignored index, rounding of a half, clip high and low, then restore
   task automatic test_coefficient_load();
      send_request(coef_req(4'(NUM_COEF), 32'sh1234_5678));
      send_request(coef_req(4'(COEF_XX), 32'sh1));
      send_request(coef_req(4'(COEF_YY), 32'sh7FFF_FFFF));
      send_request(coef_req(4'(COEF_ZZ), 32'sh8000_0000));
      send_request(coef_req(4'(COEF_ROW_STRIDE + OFFSET_COL), -32'sh1));
      send_request(point_req(32'sh8000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
      send_request(point_req(-32'sh8000, 32'sh8000_0000, '0, 1'b1));
      send_request(coef_req(4'(COEF_XX), ONE_Q16));
      send_request(coef_req(4'(COEF_YY), ONE_Q16));
      send_request(coef_req(4'(COEF_ZZ), ONE_Q16));
      send_request(coef_req(4'(COEF_ROW_STRIDE + OFFSET_COL), '0));
   endtask

   // Clouds of random points with set-up in between and some noise
   task automatic test_random_clouds();
      int n_setup;
      int n_points;
      while (requests_taken < RANDOM_ITEMS) begin
         // some clouds run flat out on both sides
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         n_setup  = $urandom_range(0, 4);
         n_points = $urandom_range(1, 30);
         repeat (n_setup) random_setup_step();
         for (int i = 0; i < n_points; i++) begin
            if ($urandom_range(0, 19) == 0) random_setup_step();
            random_point(i == n_points - 1);
         end
         if ($urandom_range(0, 7) == 0) hold_until_drained();
      end
   endtask

   // Response side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (recv_idle_on) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle_length()) @(posedge clock);
         end
      end
   end

   task automatic check_field(input string name, input logic [WORD_BITS-1:0] want,
                              input logic [WORD_BITS-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Compare every accepted response with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response transaction");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_x",      want.x,     rsp_bus.out_x);
            check_field("out_y",      want.y,     rsp_bus.out_y);
            check_field("out_z",      want.z,     rsp_bus.out_z);
            check_field("out_r",      WORD_BITS'(want.r), WORD_BITS'(rsp_bus.out_r));
            check_field("out_g",      WORD_BITS'(want.g), WORD_BITS'(rsp_bus.out_g));
            check_field("out_b",      WORD_BITS'(want.b), WORD_BITS'(rsp_bus.out_b));
            check_field("kept_index", want.index, rsp_bus.kept_index);
            check_field("point_kept", WORD_BITS'(want.kept),
                        WORD_BITS'(rsp_bus.point_kept));
            check_field("cloud_end",  WORD_BITS'(want.cloud_end),
                        WORD_BITS'(rsp_bus.cloud_end));
            check_field("saturated",  WORD_BITS'(want.sat),
                        WORD_BITS'(rsp_bus.saturated));
         end
      end
   end

   // Abandon the run after too long without any transaction
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      @(negedge reset);
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      // hold every input at a known value from time zero
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_POINT;
      req_bus.coord_x    <= '0;
      req_bus.coord_y    <= '0;
      req_bus.coord_z    <= '0;
      req_bus.corner_x   <= '0;
      req_bus.corner_y   <= '0;
      req_bus.corner_z   <= '0;
      req_bus.color_r    <= '0;
      req_bus.color_g    <= '0;
      req_bus.color_b    <= '0;
      req_bus.slot       <= '0;
      req_bus.point_last <= 1'b0;

      // shadow state after reset: no boxes, identity transform
      for (int s = 0; s < BOX_SLOTS; s++) box_on[s] = 1'b0;
      for (int c = 0; c < NUM_COEF; c++) affine[c] = '0;
      affine[COEF_XX] = ONE_Q16;
      affine[COEF_YY] = ONE_Q16;
      affine[COEF_ZZ] = ONE_Q16;
      kept_tally      = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_identity_passthrough();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      test_box_culling();
      test_coefficient_load();
      hold_until_drained();
      test_random_clouds();

      // drain, then allow the pipeline to settle so strays are caught
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
sv/pbct_pkg.sv
sv/pbct_if.sv
sv/pbct_box_cell.sv
sv/pbct_xform.sv
sv/point_box_cull_transform_top.sv
tb/tb_point_box_cull_transform_top.sv
